FILE: rtl/core/mts_pkg.sv
// Shared constants and types of the move-to-front thread store.
package mts_pkg;

  localparam int unsigned MaxThreads  = 16;
  localparam int unsigned MaxMessages = 8;

  localparam int unsigned SlotW  = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int unsigned TCntW  = $clog2(MaxThreads + 1);
  localparam int unsigned HeadW  = (MaxMessages > 1) ? $clog2(MaxMessages) : 1;
  localparam int unsigned MCntW  = $clog2(MaxMessages + 1);
  localparam int unsigned MsgAw  = $clog2(MaxThreads * MaxMessages);

  localparam logic OpAdd  = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusThreadOor = 2'd1;
  localparam logic [1:0] StatusMsgOor    = 2'd2;

  typedef struct packed {
    logic [31:0]      key;
    logic [7:0]       category;
    logic [MCntW-1:0] count;
    logic [HeadW-1:0] head;
  } meta_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] stamp;
  } msg_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sender_key;
    logic [7:0]  category_code;
    logic [15:0] message_handle;
    logic [31:0] stamp;
    logic [3:0]  thread_index;
    logic [2:0]  message_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        was_new;
    logic        evicted;
    logic [3:0]  prior_position;
    logic [4:0]  thread_total;
    logic [3:0]  message_total;
    logic [31:0] read_sender;
    logic [7:0]  read_category;
    logic [15:0] read_handle;
    logic [31:0] read_stamp;
  } rsp_t;

endpackage

FILE: rtl/core/mts_if.sv
// Valid/ready channels carrying request and response items.
interface mts_req_if import mts_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mts_rsp_if import mts_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mru_thread_store.sv
// Top level of the move-to-front thread store.
//
// The store keeps up to MaxThreads sender threads in most-recent-first order.
// Each request item is either an add or a read, and gives exactly one response
// item. Thread data lives in physical slots: a small register map translates
// list positions to slots, so moving a thread to the front rotates only the
// map. Per-slot metadata (key, category, message count, ring head) sits in a
// 16-entry synchronous memory and the message histories in a 128-entry
// synchronous memory, one ring buffer per slot, newest first from the head.
// An add searches the list one position at a time, each step a memory read
// (StScan) and then a compare (StCmp). Its response is ready once the sender
// is found, or once a new thread is made when the search runs off the end of
// the list. A read fetches the thread's metadata and then the message; it
// finishes early when the message index is out of range, and earlier still
// when the thread index is. After each item the block returns to idle, in
// which it takes the next request, so the response may still wait at the
// output register then; a stalled output holds the block until that response
// is taken.
// Memory contents need no clearing after reset.
module mru_thread_store import mts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mts_req_if.sink   in_i,
  mts_rsp_if.source out_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StScan  = 8'b0000_0010,
    StCmp   = 8'b0000_0100,
    StNew   = 8'b0000_1000,
    StUpd   = 8'b0001_0000,
    StRdMet = 8'b0010_0000,
    StRdMsg = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  meta_t meta_mem [MaxThreads];
  msg_t  msg_mem  [MaxThreads * MaxMessages];

  logic [SlotW-1:0] perm_q [MaxThreads];
  logic [TCntW-1:0] count_q;
  logic [SlotW-1:0] idx_q;     // search position, then target position
  logic [SlotW-1:0] slot_q;
  meta_t            cur_q;     // metadata of the thread being updated
  req_t             req_q;
  rsp_t             res_q;
  logic             out_valid_q;
  rsp_t             out_data_q;

  logic [SlotW-1:0] meta_raddr;
  meta_t            meta_rd_q;
  logic [MsgAw-1:0] msg_raddr;
  msg_t             msg_rd_q;

  logic [MCntW-1:0] new_cnt;
  logic [HeadW-1:0] new_head;
  logic [7:0]       ptr_sum;
  logic [HeadW-1:0] rd_ptr;
  logic             out_free;

  function automatic logic [MsgAw-1:0] msg_addr(logic [SlotW-1:0] slot,
                                                logic [HeadW-1:0] ptr);
    logic [MsgAw+7:0] a;
    a = (MsgAw+8)'(slot) * (MsgAw+8)'(MaxMessages) + (MsgAw+8)'(ptr);
    return a[MsgAw-1:0];
  endfunction

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Message update of the front thread, and the ring read pointer of a read.
  always_comb begin
    new_cnt  = (cur_q.count < MCntW'(MaxMessages)) ? cur_q.count + 1'b1
                                                   : MCntW'(MaxMessages);
    new_head = (cur_q.head == '0) ? HeadW'(MaxMessages - 1) : cur_q.head - 1'b1;
    ptr_sum  = 8'(meta_rd_q.head) + 8'(req_q.message_index);
    if (ptr_sum >= 8'(MaxMessages)) begin
      ptr_sum = ptr_sum - 8'(MaxMessages);
    end
    rd_ptr = ptr_sum[HeadW-1:0];
  end

  // While idle, the metadata of the addressed thread is fetched at once so a
  // read finds it in the first cycle after acceptance.
  always_comb begin
    if (state_q == StIdle) begin
      meta_raddr = perm_q[in_i.data.thread_index[SlotW-1:0]];
    end else begin
      meta_raddr = perm_q[idx_q];
    end
    msg_raddr  = msg_addr(slot_q, rd_ptr);
  end

  always_ff @(posedge clk_i) begin
    meta_rd_q <= meta_mem[meta_raddr];
    msg_rd_q  <= msg_mem[msg_raddr];
    if (state_q == StUpd) begin
      meta_mem[slot_q] <= '{key: req_q.sender_key, category: req_q.category_code,
                            count: new_cnt, head: new_head};
      msg_mem[msg_addr(slot_q, new_head)] <= '{handle: req_q.message_handle,
                                               stamp: req_q.stamp};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_i.valid) begin
        if (in_i.data.opcode == OpRead) begin
          state_d = (TCntW'(in_i.data.thread_index) >= count_q) ? StDone : StRdMet;
        end else begin
          state_d = (count_q == '0) ? StNew : StScan;
        end
      end
      StScan:  state_d = StCmp;
      StCmp: begin
        if (meta_rd_q.key == req_q.sender_key) state_d = StUpd;
        else if (TCntW'(idx_q) == count_q - 1'b1) state_d = StNew;
        else state_d = StScan;
      end
      StNew:   state_d = StUpd;
      StUpd:   state_d = StDone;
      StRdMet: state_d = (4'(meta_rd_q.count) <= 4'(req_q.message_index)) ? StDone
                                                                         : StRdMsg;
      StRdMsg: state_d = StDone;
      StDone:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MaxThreads; j++) perm_q[j] <= SlotW'(j);
    end else begin
      state_q <= state_d;
      if (state_q == StDone && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_i.valid) begin
          if (in_i.data.opcode == OpRead &&
              TCntW'(in_i.data.thread_index) < count_q) begin
            idx_q <= in_i.data.thread_index[SlotW-1:0];
          end else begin
            idx_q <= '0;
          end
        end
        StCmp: if (meta_rd_q.key != req_q.sender_key) idx_q <= idx_q + 1'b1;
        StNew: begin
          if (count_q == TCntW'(MaxThreads)) begin
            idx_q <= SlotW'(MaxThreads - 1);
          end else begin
            idx_q   <= count_q[SlotW-1:0];
            count_q <= count_q + 1'b1;
          end
        end
        StUpd: begin
          perm_q[0] <= slot_q;
          for (int j = 1; j < MaxThreads; j++) begin
            if (SlotW'(j) <= idx_q) perm_q[j] <= perm_q[j-1];
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: if (in_i.valid) begin
        req_q <= in_i.data;
        res_q <= '{status: (in_i.data.opcode == OpRead &&
                            TCntW'(in_i.data.thread_index) >= count_q) ?
                           StatusThreadOor : StatusOk,
                   thread_total: 5'(count_q),
                   default: '0};
        if (in_i.data.opcode == OpRead) begin
          slot_q <= perm_q[in_i.data.thread_index[SlotW-1:0]];
        end
      end
      StCmp: if (meta_rd_q.key == req_q.sender_key) begin
        slot_q <= perm_q[idx_q];
        cur_q  <= meta_rd_q;
        res_q.prior_position <= 4'(idx_q);
      end
      StNew: begin
        res_q.was_new <= 1'b1;
        cur_q.count   <= '0;
        cur_q.head    <= '0;
        if (count_q == TCntW'(MaxThreads)) begin
          res_q.evicted <= 1'b1;
          slot_q <= perm_q[MaxThreads-1];
        end else begin
          slot_q <= perm_q[count_q[SlotW-1:0]];
          res_q.thread_total <= 5'(count_q + 1'b1);
        end
      end
      StUpd: res_q.message_total <= 4'(new_cnt);
      StRdMet: begin
        res_q.read_sender   <= meta_rd_q.key;
        res_q.read_category <= meta_rd_q.category;
        res_q.message_total <= 4'(meta_rd_q.count);
        if (4'(meta_rd_q.count) <= 4'(req_q.message_index)) begin
          res_q.status <= StatusMsgOor;
        end
      end
      StRdMsg: begin
        res_q.read_handle <= msg_rd_q.handle;
        res_q.read_stamp  <= msg_rd_q.stamp;
      end
      StDone: if (out_free) out_data_q <= res_q;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The thread count never exceeds the table size.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TCntW'(MaxThreads)) else $error("thread count above table size");
  // A response appears only when the item finishes.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone)) else $error("stray response");
  // A new thread grows the count unless it evicted the oldest one.
  a_new_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNew && count_q != TCntW'(MaxThreads)) |=> count_q == $past(count_q) + 1'b1)
    else $error("count did not grow on a new thread");
`endif

endmodule
